// File: rtl/wdt_pkg.sv
// Shared definitions for the watchdog timer device: access codes, mode codes,
// field widths and the per-request result record. No dependencies.
package wdt_pkg;

    localparam int WORD_W  = 12;
    localparam int COUNT_W = 9;
    localparam int MODE_W  = 3;
    localparam int FUNC_W  = 3;

    // Access function codes
    localparam logic [FUNC_W-1:0] FN_NOP     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SKIP    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RESTART = 3'd4;

    // Watchdog modes
    localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RST_ONE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RST_PER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HLT_ONE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HLT_PER = 3'd4;
    localparam logic [MODE_W-1:0] MODE_IRQ_ONE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_IRQ_PER = 3'd6;

    typedef struct packed {
        logic [WORD_W-1:0]  ac_out;
        logic               ac_load;
        logic               skip;
        logic               jump_to_zero;
        logic               halt_request;
        logic               interrupt_request;
        logic               enabled_flag;
        logic               expired_flag;
        logic [COUNT_W-1:0] remaining_ticks;
    } wdt_result_t;

endpackage

// File: rtl/wdt_core.sv
// Watchdog state registers and the single-pass update for one request.
// Depends on wdt_pkg for codes, widths and the result record.
module wdt_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        take_i,   // request accepted this cycle
    input  logic                        cmd_i,    // 0 tick, 1 bus access
    input  logic [wdt_pkg::FUNC_W-1:0]  func_i,
    input  logic [wdt_pkg::WORD_W-1:0]  ac_i,
    output wdt_pkg::wdt_result_t        res_o
);

    logic [wdt_pkg::MODE_W-1:0]  mode_reg, mode_next;
    logic [wdt_pkg::COUNT_W-1:0] reload_reg, reload_next;
    logic [wdt_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        enabled_reg, enabled_next;
    logic                        expired_reg, expired_next;

    logic [wdt_pkg::COUNT_W-1:0] dec_count;
    logic                        periodic;
    logic [wdt_pkg::MODE_W-1:0]  wr_mode;

    assign wr_mode   = ac_i[wdt_pkg::WORD_W-1:wdt_pkg::COUNT_W];
    assign dec_count = (count_reg != '0) ? count_reg - 1'b1 : '0;
    assign periodic  = mode_reg inside {wdt_pkg::MODE_RST_PER, wdt_pkg::MODE_HLT_PER,
                                        wdt_pkg::MODE_IRQ_PER};

    always_comb begin
        mode_next    = mode_reg;
        reload_next  = reload_reg;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        expired_next = expired_reg;
        res_o        = '0;

        if (cmd_i) begin
            case (func_i)
                wdt_pkg::FN_SKIP: begin
                    res_o.skip = expired_reg;
                end
                wdt_pkg::FN_WRITE: begin
                    mode_next    = wr_mode;
                    reload_next  = ac_i[wdt_pkg::COUNT_W-1:0];
                    expired_next = 1'b0;
                    enabled_next = (wr_mode != wdt_pkg::MODE_OFF);
                    count_next   = (wr_mode != wdt_pkg::MODE_OFF) ?
                                   ac_i[wdt_pkg::COUNT_W-1:0] : '0;
                end
                wdt_pkg::FN_READ: begin
                    res_o.ac_out  = {mode_reg, reload_reg};
                    res_o.ac_load = 1'b1;
                end
                wdt_pkg::FN_RESTART: begin
                    expired_next = 1'b0;
                    count_next   = reload_reg;
                    enabled_next = (mode_reg != wdt_pkg::MODE_OFF);
                end
                default: begin
                    // no operation and unused codes: status only
                end
            endcase
        end else if (enabled_reg && !expired_reg) begin
            count_next = dec_count;
            if (dec_count == '0) begin
                expired_next = 1'b1;
                enabled_next = periodic;
                res_o.jump_to_zero      = mode_reg inside {wdt_pkg::MODE_RST_ONE,
                                                           wdt_pkg::MODE_RST_PER};
                res_o.halt_request      = mode_reg inside {wdt_pkg::MODE_HLT_ONE,
                                                           wdt_pkg::MODE_HLT_PER};
                res_o.interrupt_request = mode_reg inside {wdt_pkg::MODE_IRQ_ONE,
                                                           wdt_pkg::MODE_IRQ_PER};
                // periodic reload, unless the count is zero
                if (periodic && reload_reg != '0) begin
                    count_next   = reload_reg;
                    expired_next = 1'b0;
                end
            end
        end

        res_o.enabled_flag    = enabled_next;
        res_o.expired_flag    = expired_next;
        res_o.remaining_ticks = enabled_next ? count_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= wdt_pkg::MODE_OFF;
            reload_reg  <= '0;
            count_reg   <= '0;
            enabled_reg <= 1'b0;
            expired_reg <= 1'b0;
        end else if (take_i) begin
            mode_reg    <= mode_next;
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            enabled_reg <= enabled_next;
            expired_reg <= expired_next;
        end
    end

    // at most one expiry request per step
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({res_o.jump_to_zero, res_o.halt_request, res_o.interrupt_request}))
        else $error("more than one expiry request");

    // a write with a nonzero mode arms the watchdog
    a_write_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (take_i && cmd_i && func_i == wdt_pkg::FN_WRITE && wr_mode != wdt_pkg::MODE_OFF)
        |=> (enabled_reg && !expired_reg))
        else $error("write did not arm watchdog");

    // enabled with expired set only happens for a periodic mode with zero count
    a_stuck_periodic: assert property (@(posedge aclk) disable iff (!aresetn)
        (enabled_reg && expired_reg) |-> (periodic && reload_reg == '0))
        else $error("expired while enabled outside zero-count periodic mode");

    // disabled watchdog reports no remaining ticks
    a_rem_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_o.remaining_ticks != '0) |-> res_o.enabled_flag)
        else $error("remaining ticks reported while disabled");

endmodule

// File: rtl/watchdog_timer_device.sv
// Watchdog timer device top level: stream ports, output register.
// Depends on wdt_pkg and wdt_core.
//
//  channel | dir | tdata (low bit up)                            | tuser
//  --------+-----+-----------------------------------------------+-----------------
//  s_      | in  | func[2:0], ac_in[14:3], pad[15]               | cmd (0 tick, 1 access)
//  m_      | out | ac_out[11:0], skip, jump_to_zero, halt_request,| ac_load
//          |     | interrupt_request, enabled, expired, ticks    |
//
// One request per cycle while s_tready is high, one result per request, shown on m_
// in the cycle after the request is accepted. The state update and the result are one
// pass of logic between the input handshake and the m_ output register.
// s_tready is high whenever the output register is empty or being drained,
// so a stalled m_ side stops intake only while a result is held.
// aresetn is synchronous, active low; it clears the watchdog and the output valid.
module watchdog_timer_device (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] func, [14:3] ac_in, [15] zero
    input  logic        s_tuser,   // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [11:0] ac_out, [12] skip, [13] jump_to_zero,
                                   // [14] halt_request, [15] interrupt_request,
                                   // [16] enabled_flag, [17] expired_flag,
                                   // [26:18] remaining_ticks, [31:27] zero
    output logic        m_tuser    // ac_load
);

    logic                 take;
    wdt_pkg::wdt_result_t res;
    wdt_pkg::wdt_result_t res_reg;
    logic                 valid_reg;

    // accept when the result slot is free or emptying this cycle
    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    wdt_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take_i  (take),
        .cmd_i   (s_tuser),
        .func_i  (s_tdata[wdt_pkg::FUNC_W-1:0]),
        .ac_i    (s_tdata[wdt_pkg::FUNC_W +: wdt_pkg::WORD_W]),
        .res_o   (res)
    );

    // result register: valid is control, payload loads on accept only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (take) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.ac_load;
    assign m_tdata  = {5'd0,
                       res_reg.remaining_ticks,
                       res_reg.expired_flag,
                       res_reg.enabled_flag,
                       res_reg.interrupt_request,
                       res_reg.halt_request,
                       res_reg.jump_to_zero,
                       res_reg.skip,
                       res_reg.ac_out};

endmodule

// File: dv/testbench.sv
// Self-checking testbench for watchdog_timer_device: directed and random requests,
// a bit-exact predictor of the watchdog and a per-field result check.
// Depends on wdt_pkg and the watchdog_timer_device RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int WORD_W  = wdt_pkg::WORD_W;
    localparam int COUNT_W = wdt_pkg::COUNT_W;
    localparam int MODE_W  = wdt_pkg::MODE_W;
    localparam int FUNC_W  = wdt_pkg::FUNC_W;

    // tuser on the request side
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    // codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;
    localparam logic [MODE_W-1:0] MODE_QUIET     = 3'd7;   // counts, never requests

    // receiver behavior
    localparam int RX_ALWAYS  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_HOLD    = 200;   // cycles of the long hold-off

    localparam int RANDOM_ITEMS = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [2:0] func, [14:3] ac_in, [15] zero
    logic        s_tuser  = 1'b0;  // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [11:0] ac_out, [12] skip, [13] jump_to_zero,
                                   // [14] halt_request, [15] interrupt_request,
                                   // [16] enabled_flag, [17] expired_flag,
                                   // [26:18] remaining_ticks, [31:27] zero
    logic        m_tuser;          // ac_load

    // predicted watchdog state
    logic [MODE_W-1:0]  wd_mode;
    logic [COUNT_W-1:0] wd_reload;
    logic [COUNT_W-1:0] wd_count;
    logic               wd_enabled;
    logic               wd_expired;

    wdt_pkg::wdt_result_t pending_results[$];   // expected results, oldest first
    int mismatches  = 0;
    int items_sent  = 0;

    // idling knobs
    bit tx_gaps     = 1'b1;
    int burst_left  = 1;
    int rx_style    = RX_RANDOM;
    int holds_asked = 0;

    // receiver stall state
    int         holds_taken = 0;
    int         hold_left   = 0;
    logic [7:0] rx_pat      = 8'b1101_0110;

    watchdog_timer_device i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one request to the shadow state, returns the
    // result the device should produce for it.
    // ------------------------------------------------------------------
    function automatic wdt_pkg::wdt_result_t predict_watchdog(
            input logic cmd, input logic [FUNC_W-1:0] fn, input logic [WORD_W-1:0] ac);
        wdt_pkg::wdt_result_t r;
        r = '0;
        if (cmd == CMD_ACCESS) begin
            case (fn)
                wdt_pkg::FN_SKIP: begin
                    r.skip = wd_expired;
                end
                wdt_pkg::FN_WRITE: begin
                    wd_mode    = ac[WORD_W-1:COUNT_W];
                    wd_reload  = ac[COUNT_W-1:0];
                    wd_expired = 1'b0;
                    wd_enabled = (wd_mode != wdt_pkg::MODE_OFF);
                    wd_count   = wd_enabled ? wd_reload : '0;
                end
                wdt_pkg::FN_READ: begin
                    r.ac_out  = {wd_mode, wd_reload};
                    r.ac_load = 1'b1;
                end
                wdt_pkg::FN_RESTART: begin
                    wd_expired = 1'b0;
                    wd_count   = wd_reload;
                    wd_enabled = (wd_mode != wdt_pkg::MODE_OFF);
                end
                default: ;   // no-op and spare codes only report status
            endcase
        end else if (wd_enabled && !wd_expired) begin
            if (wd_count != '0)
                wd_count = wd_count - 1'b1;
            if (wd_count == '0) begin
                wd_expired = 1'b1;
                // only periodic modes survive expiry; quiet mode acts one-shot
                wd_enabled = wd_mode inside {wdt_pkg::MODE_RST_PER, wdt_pkg::MODE_HLT_PER,
                                             wdt_pkg::MODE_IRQ_PER};
                r.jump_to_zero      = wd_mode inside {wdt_pkg::MODE_RST_ONE,
                                                      wdt_pkg::MODE_RST_PER};
                r.halt_request      = wd_mode inside {wdt_pkg::MODE_HLT_ONE,
                                                      wdt_pkg::MODE_HLT_PER};
                r.interrupt_request = wd_mode inside {wdt_pkg::MODE_IRQ_ONE,
                                                      wdt_pkg::MODE_IRQ_PER};
                // zero reload leaves a periodic watchdog parked in expired
                if (wd_enabled && wd_reload != '0) begin
                    wd_count   = wd_reload;
                    wd_expired = 1'b0;
                end
            end
        end
        r.enabled_flag    = wd_enabled;
        r.expired_flag    = wd_expired;
        r.remaining_ticks = wd_enabled ? wd_count : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive at falling edge, hold until the handshake at a rising
    // edge. Valid stays high into the next request; gaps and
    // wait_results_drained lower it.
    // ------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [FUNC_W-1:0] fn,
                                input logic [WORD_W-1:0] ac);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, ac, fn};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_watchdog(cmd, fn, ac));
        items_sent++;
        if (tx_gaps) begin
            burst_left--;
            if (burst_left <= 0) begin
                gap = $urandom_range(1, 8);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // fully random request, fields over their whole range
    task automatic send_noise();
        send_request(1'($urandom_range(0, 1)), FUNC_W'($urandom_range(0, 7)),
                     WORD_W'($urandom_range(0, 4095)));
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls by style, plus long hold-offs counted here.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : rx_stall
        if (hold_left == 0 && holds_taken != holds_asked) begin
            holds_taken++;
            hold_left = RX_HOLD;
        end
        rx_pat = {rx_pat[6:0], rx_pat[7]};
        if ($urandom_range(0, 63) == 0)
            rx_pat = 8'($urandom) | 8'h01;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_style)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= rx_pat[7];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check: each accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        wdt_pkg::wdt_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: tdata 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("ac_out", 32'(want.ac_out), 32'(m_tdata[11:0]));
                check_field("ac_load", 32'(want.ac_load), 32'(m_tuser));
                check_field("skip", 32'(want.skip), 32'(m_tdata[12]));
                check_field("jump_to_zero", 32'(want.jump_to_zero), 32'(m_tdata[13]));
                check_field("halt_request", 32'(want.halt_request), 32'(m_tdata[14]));
                check_field("interrupt_request", 32'(want.interrupt_request),
                            32'(m_tdata[15]));
                check_field("enabled_flag", 32'(want.enabled_flag), 32'(m_tdata[16]));
                check_field("expired_flag", 32'(want.expired_flag), 32'(m_tdata[17]));
                check_field("remaining_ticks", 32'(want.remaining_ticks),
                            32'(m_tdata[26:18]));
                check_field("tdata pad", 32'd0, 32'(m_tdata[31:27]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // status after reset: nothing armed, nothing expired
    task automatic test_after_reset();
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,  '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_NOP,  12'hFFF);
        send_request(CMD_ACCESS, wdt_pkg::FN_SKIP, '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_READ, '0);
        wait_results_drained();
    endtask

    // control word write/readback with all fields at their maximum, spare codes ignored
    task automatic test_control_word();
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {MODE_QUIET, 9'h1FF});
        send_request(CMD_ACCESS, wdt_pkg::FN_READ,  '0);
        for (int f = FN_SPARE_FIRST; f <= FN_SPARE_LAST; f++)
            send_request(CMD_ACCESS, FUNC_W'(f), 12'hFFF);
        wait_results_drained();
    endtask

    // expiry in each request class, periodic reload, zero count, restart
    task automatic test_expiry_modes();
        // one-shot reset mode: two ticks, then skip sees expired
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_RST_ONE, 9'd2});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_SKIP,  '0);
        // periodic with count one reloads every tick
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_RST_PER, 9'd1});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        // periodic halt with zero count fires once, then stays parked
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_HLT_PER, 9'd0});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_RESTART, '0);
        // one-shot halt
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_HLT_ONE, 9'd1});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        // one-shot interrupt, restart rearms it
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_IRQ_ONE, 9'd1});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_RESTART, '0);
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        // quiet mode expires without any request
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {MODE_QUIET, 9'd1});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        // disabling write, then a tick does nothing
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_OFF, 9'd3});
        send_request(CMD_TICK,   wdt_pkg::FN_NOP,   '0);
        wait_results_drained();
    endtask

    // long receiver hold-off while the sender keeps offering; then a full pause
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_IRQ_PER, 9'd3});
        holds_asked++;
        repeat (24) begin
            if ($urandom_range(0, 2) != 0)
                send_request(CMD_TICK, FUNC_W'($urandom_range(0, 7)), '0);
            else
                send_noise();
        end
        wait_results_drained();
        tx_gaps = 1'b1;
    endtask

    // largest count runs all the way down and reloads; no idling here
    task automatic test_full_count();
        rx_style = RX_ALWAYS;
        tx_gaps  = 1'b0;
        send_request(CMD_ACCESS, wdt_pkg::FN_WRITE, {wdt_pkg::MODE_IRQ_PER, 9'h1FF});
        repeat (512) send_request(CMD_TICK, '0, '0);
        send_request(CMD_ACCESS, wdt_pkg::FN_READ, '0);
        wait_results_drained();
    endtask

    // random sequences: write a control word, then mostly ticks; some are bursts of fully random requests
    task automatic test_random_traffic();
        int                 seqs;
        int                 run;
        logic [COUNT_W-1:0] cnt;
        int                 pick;
        seqs = 0;
        while (items_sent < RANDOM_ITEMS + 600) begin
            if (seqs % 10 == 0) begin
                tx_gaps  = ($urandom_range(0, 3) != 0);
                rx_style = $urandom_range(RX_ALWAYS, RX_PATTERN);
            end
            seqs++;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) send_noise();
                continue;
            end
            pick = $urandom_range(0, 19);
            if (pick < 16)      cnt = COUNT_W'($urandom_range(0, 7));
            else if (pick < 19) cnt = COUNT_W'($urandom_range(8, 40));
            else                cnt = COUNT_W'($urandom_range(0, 511));
            send_request(CMD_ACCESS, wdt_pkg::FN_WRITE,
                         {MODE_W'($urandom_range(0, 7)), cnt});
            run = (cnt <= 40) ? $urandom_range(1, 2 * cnt + 4) : $urandom_range(1, 30);
            repeat (run) begin
                if ($urandom_range(0, 3) != 0)
                    send_request(CMD_TICK, FUNC_W'($urandom_range(0, 7)),
                                 WORD_W'($urandom_range(0, 4095)));
                else
                    send_request(CMD_ACCESS, FUNC_W'($urandom_range(0, 7)),
                                 WORD_W'($urandom_range(0, 4095)));
            end
        end
        wait_results_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        wd_mode    = wdt_pkg::MODE_OFF;
        wd_reload  = '0;
        wd_count   = '0;
        wd_enabled = 1'b0;
        wd_expired = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_control_word();
        test_expiry_modes();
        test_backpressure();
        test_full_count();
        test_random_traffic();

        // leave room for any stray result
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
